[rtl/core/wdd_pkg.sv]
// Package for the weighted distance / inner product block.
// Holds payload and control types, field widths and register indexes.
// Used by every module in rtl/core; depends on nothing.
package wdd_pkg;

   localparam int VALUE_WIDTH       = 16;
   localparam int FRAC_BITS         = 8;
   localparam int METRIC_WIDTH      = 48;
   localparam int ACC_WIDTH_DEFAULT = 48;
   localparam int CSR_INDEX_WIDTH   = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_METRIC_MODE   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WEIGHT_ENABLE = 1'b1;

   localparam logic MODE_EUCLID = 1'b0;
   localparam logic MODE_INNER  = 1'b1;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] first_value;
      logic signed [VALUE_WIDTH-1:0] second_value;
      logic signed [VALUE_WIDTH-1:0] weight;
      logic                          last_component;
   } req_payload_type;

   typedef struct packed {
      logic signed [METRIC_WIDTH-1:0] metric_value;
      logic                           overflow;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_ROOT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic weigh_load;
      logic mul_load;
      logic acc_add;
      logic root_load;
      logic root_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic mode_inner;
      logic root_last;
   } status_type;

endpackage

[rtl/core/wdd_ctrl.sv]
// Controller state machine for the weighted distance / inner product block.
// Sequences weighting, multiply, accumulate, square root and result hand-off.
// Depends on wdd_pkg.
module wdd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  wdd_pkg::status_type  status,
   output wdd_pkg::cmd_type     cmd
);

   wdd_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wdd_pkg::S_IDLE: begin
            if (req_valid) state_in = wdd_pkg::S_MUL;
         end
         wdd_pkg::S_MUL: begin
            state_in = wdd_pkg::S_ACC;
         end
         wdd_pkg::S_ACC: begin
            if (!status.last) state_in = wdd_pkg::S_IDLE;
            else if (status.mode_inner) state_in = wdd_pkg::S_EMIT;
            else state_in = wdd_pkg::S_ROOT;
         end
         wdd_pkg::S_ROOT: begin
            if (status.root_last) state_in = wdd_pkg::S_EMIT;
         end
         wdd_pkg::S_EMIT: begin
            if (out_free) state_in = wdd_pkg::S_IDLE;
         end
         default: begin
            state_in = wdd_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         wdd_pkg::S_IDLE: begin
            req_stall      = 1'b0;
            cmd.weigh_load = req_valid;
         end
         wdd_pkg::S_MUL: begin
            cmd.mul_load = 1'b1;
         end
         wdd_pkg::S_ACC: begin
            cmd.acc_add   = 1'b1;
            cmd.root_load = status.last && !status.mode_inner;
         end
         wdd_pkg::S_ROOT: begin
            cmd.root_step = 1'b1;
         end
         wdd_pkg::S_EMIT: begin
            cmd.out_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wdd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("Result register loaded while a stalled result is pending.");

   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == wdd_pkg::S_MUL)
      else $error("Accepted request did not move to the multiply step.");

   a_root_euclid: assert property (@(posedge clock) disable iff (reset)
      state_ff == wdd_pkg::S_ROOT |-> !status.mode_inner)
      else $error("Square root running in inner-product mode.");
`endif

endmodule

[rtl/core/wdd_datapath.sv]
// Datapath for the weighted distance / inner product block.
// Holds configuration, weighting, multiplier, saturating accumulator,
// digit-by-digit square root and the result register. Depends on wdd_pkg.
module wdd_datapath #(
   parameter int ACC_WIDTH = wdd_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [wdd_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [0:0]                               csr_wdata,
   input  wdd_pkg::req_payload_type                 req_payload,
   input  wdd_pkg::cmd_type                         cmd,
   output wdd_pkg::status_type                      status,
   output wdd_pkg::rsp_payload_type                 rsp_payload
);

   localparam int VW     = wdd_pkg::VALUE_WIDTH;
   localparam int FB     = wdd_pkg::FRAC_BITS;
   localparam int QW     = 2 * VW - FB;
   localparam int DW     = VW + 1;
   localparam int PROD_W = 2 * DW;
   localparam int SUM_W  = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
   localparam int RES_W  = (ACC_WIDTH + 1) / 2;
   localparam int RAD_W  = 2 * RES_W;
   localparam int CNT_W  = $clog2(RES_W);
   localparam int MW     = wdd_pkg::METRIC_WIDTH;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [VW-1:0]        VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0]        VAL_MIN = {1'b1, {(VW-1){1'b0}}};

   function automatic logic signed [VW-1:0] weigh(input logic signed [VW-1:0] v,
                                                  input logic signed [VW-1:0] w);
      logic signed [2*VW-1:0] p;
      logic signed [QW-1:0]   q;
      logic signed [VW-1:0]   r;
      p = v * w;
      q = p[2*VW-1:FB];
      if (q > QW'(VAL_MAX)) r = VAL_MAX;
      else if (q < QW'(VAL_MIN)) r = VAL_MIN;
      else r = q[VW-1:0];
      return r;
   endfunction

   logic mode_ff, mode_in;
   logic wen_ff, wen_in;
   logic signed [VW-1:0] wa_ff, wa_in, wb_ff, wb_in;
   logic last_ff, last_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in, acc_sum;
   logic sat_ff, sat_in, sat_hit;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [RES_W:0] rem_ff, rem_in;
   logic [RES_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   wdd_pkg::rsp_payload_type out_ff, out_in;

   logic signed [DW-1:0] diff, op_a, op_b;
   logic signed [SUM_W-1:0] sum;
   logic [RES_W+1:0] rem_sh, trial;
   logic signed [63:0] acc_wide;

   always_comb begin
      mode_in = mode_ff;
      wen_in  = wen_ff;
      if (csr_we) begin
         case (csr_index)
            wdd_pkg::CSR_METRIC_MODE:   mode_in = csr_wdata[0];
            wdd_pkg::CSR_WEIGHT_ENABLE: wen_in  = csr_wdata[0];
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      wa_in   = wa_ff;
      wb_in   = wb_ff;
      last_in = last_ff;
      if (cmd.weigh_load) begin
         last_in = req_payload.last_component;
         if (wen_ff) begin
            wa_in = weigh(req_payload.first_value, req_payload.weight);
            wb_in = weigh(req_payload.second_value, req_payload.weight);
         end else begin
            wa_in = req_payload.first_value;
            wb_in = req_payload.second_value;
         end
      end
   end

   always_comb begin
      diff = DW'(wa_ff) - DW'(wb_ff);
      if (mode_ff == wdd_pkg::MODE_INNER) begin
         op_a = DW'(wa_ff);
         op_b = DW'(wb_ff);
      end else begin
         op_a = diff;
         op_b = diff;
      end
      prod_in = cmd.mul_load ? PROD_W'(op_a * op_b) : prod_ff;
   end

   always_comb begin
      sum = SUM_W'(acc_ff) + SUM_W'(prod_ff);
      sat_hit = 1'b0;
      if (sum > SUM_W'(ACC_MAX)) begin
         acc_sum = ACC_MAX;
         sat_hit = 1'b1;
      end else if (sum < SUM_W'(ACC_MIN)) begin
         acc_sum = ACC_MIN;
         sat_hit = 1'b1;
      end else begin
         acc_sum = sum[ACC_WIDTH-1:0];
      end
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (cmd.acc_add) begin
         acc_in = acc_sum;
         sat_in = sat_ff || sat_hit;
      end else if (cmd.out_load) begin
         acc_in = '0;
         sat_in = 1'b0;
      end
   end

   always_comb begin
      rem_sh  = {rem_ff[RES_W-1:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (cmd.root_load) begin
         rad_in  = (!acc_sum[ACC_WIDTH-1] && (acc_sum != '0)) ?
                   RAD_W'($unsigned(acc_sum)) : '0;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
      end else if (cmd.root_step) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = (RES_W+1)'(rem_sh - trial);
            root_in = {root_ff[RES_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RES_W:0];
            root_in = {root_ff[RES_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      acc_wide = 64'(acc_ff);
      out_in   = out_ff;
      if (cmd.out_load) begin
         out_in.overflow = sat_ff;
         if (mode_ff == wdd_pkg::MODE_INNER) out_in.metric_value = acc_wide[MW-1:0];
         else out_in.metric_value = MW'(root_ff);
      end
   end

   assign status.last       = last_ff;
   assign status.mode_inner = (mode_ff == wdd_pkg::MODE_INNER);
   assign status.root_last  = (cnt_ff == CNT_W'(RES_W - 1));
   assign rsp_payload       = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         wen_ff  <= 1'b0;
         acc_ff  <= '0;
         sat_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         wen_ff  <= wen_in;
         acc_ff  <= acc_in;
         sat_ff  <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff   <= wa_in;
      wb_ff   <= wb_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      out_ff  <= out_in;
   end

`ifndef SYNTHESIS
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (acc_ff == '0) && !sat_ff)
      else $error("Accumulator not cleared after a result was issued.");

   a_root_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.root_load |=> cnt_ff == '0)
      else $error("Square root step count did not restart.");

   a_sat_clamps: assert property (@(posedge clock) disable iff (reset)
      $rose(sat_ff) |-> (acc_ff == ACC_MAX) || (acc_ff == ACC_MIN))
      else $error("Overflow flag set without a clamped accumulator.");
`endif

endmodule

[rtl/core/weighted_distance_or_dot.sv]
// Weighted Euclidean distance / inner product engine, top level.
// Requests carry one component pair, a Q8.8 weight and a last flag.
// Each request is accepted when req_valid is high and req_stall is low;
// req_stall is low only while the block waits for a request.
// A request is handled in order by accept with weighting, a multiply
// and a saturating accumulate.
// On the last component a response follows. In inner-product mode it is
// loaded in the emit state that follows the accumulate, once the response
// register is free; in distance mode the square root unit resolves one
// result bit per cycle for a (ACC_WIDTH+1)/2-bit root before it is loaded.
// The response register holds rsp_payload stable while rsp_stall is high;
// new requests are still taken then, but the next vector's response waits
// until the register is free.
// Configuration registers are written through csr_we, csr_index and csr_wdata;
// the user must write them only while the block is idle, which the block does not enforce.
// Synchronous reset clears the configuration, the accumulator, the
// overflow flag and any pending response.
// Depends on wdd_pkg, wdd_ctrl and wdd_datapath.
module weighted_distance_or_dot #(
   parameter int ACC_WIDTH = wdd_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wdd_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wdd_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_we,
   input  logic [wdd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [0:0]                          csr_wdata
);

   wdd_pkg::cmd_type    cmd;
   wdd_pkg::status_type status;

   wdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wdd_datapath #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule
